FILE: src/tapv_pkg.sv
// shared types, widths and constants of the three-axis pid velocity unit
package tapv_pkg;

  // fixed formats
  localparam int AXES      = 3;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 32;
  localparam int US_W      = 20;
  localparam int ACC_W     = 48;
  localparam int D_W       = DATA_W + 1;
  localparam int AX_W      = $clog2(AXES);

  // configuration port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP,
    CFG_KI,
    CFG_KD,
    CFG_PERIOD
  } cfg_idx_t;

  localparam int GAIN_RESET_INT = 35;
  localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(GAIN_RESET_INT << FRAC_BITS);
  localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(GAIN_RESET_INT << FRAC_BITS);
  localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(1 << FRAC_BITS);
  localparam logic [US_W-1:0]   US_RESET = US_W'(1000);

  // one second in microseconds, and its split into an odd factor and a power of two
  localparam int MICRO_PER_SEC = 1000000;
  localparam int I_DIV_CONST   = 15625;
  localparam int I_DIV_SHIFT   = FRAC_BITS + 6;

  // multiply unit: operand a in 32-bit chunks against a 32-bit operand b
  localparam int MUL_CHUNKS = 3;
  localparam int CHUNK_W    = 2;
  localparam int MULA_W     = 32 * MUL_CHUNKS;
  localparam int PROD_W     = 64;
  localparam int WACC_W     = 128;

  // divide unit: radix-16 restoring, four quotient bits per cycle
  localparam int DIV_W      = 80;
  localparam int DEN_W      = US_W;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // term magnitudes and final sum
  localparam int PMAG_W = 48;
  localparam int MAG_W  = 62;
  localparam int SUM_W  = 64;
  localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(1) << (MAG_W - 1);

  localparam logic [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_MUL,
    OP_POST_P,
    OP_POST_I1,
    OP_POST_I2,
    OP_POST_DIV_I,
    OP_POST_D1,
    OP_POST_D2,
    OP_POST_DIV_D,
    OP_DIV,
    OP_SUM1,
    OP_SUM2,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [AX_W-1:0]    axis;
    logic [CHUNK_W-1:0] chunk;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

FILE: src/tapv_ctrl.sv
// sequencer that steps the datapath through the three axes of one item
module tapv_ctrl import tapv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_POST,
    ST_DIV,
    ST_SUM1,
    ST_SUM2,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_P,
    PH_I1,
    PH_I2,
    PH_DIV_I,
    PH_D1,
    PH_D2,
    PH_DIV_D
  } phase_t;

  state_t             state_r;
  phase_t             phase_r;
  logic [CHUNK_W-1:0] cnt_r;
  logic [AX_W-1:0]    ax_r;
  logic               out_valid_r;
  logic               pub_ok;

  // result register free, or being emptied this cycle
  assign pub_ok    = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // command decode
  always_comb begin
    cmd.op    = OP_NONE;
    cmd.axis  = ax_r;
    cmd.chunk = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_PREP: cmd.op = OP_PREP;
      ST_MUL:  cmd.op = OP_MUL;
      ST_POST: begin
        unique case (phase_r)
          PH_P:     cmd.op = OP_POST_P;
          PH_I1:    cmd.op = OP_POST_I1;
          PH_I2:    cmd.op = OP_POST_I2;
          PH_DIV_I: cmd.op = OP_POST_DIV_I;
          PH_D1:    cmd.op = OP_POST_D1;
          PH_D2:    cmd.op = OP_POST_D2;
          PH_DIV_D: cmd.op = OP_POST_DIV_D;
          default:  cmd.op = OP_NONE;
        endcase
      end
      ST_DIV:  cmd.op = OP_DIV;
      ST_SUM1: cmd.op = OP_SUM1;
      ST_SUM2: cmd.op = OP_SUM2;
      ST_DONE: begin
        if (pub_ok) cmd.op = OP_PUBLISH;
      end
    endcase
  end

  // state, sequencing counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_P;
      cnt_r       <= '0;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_PREP;
            ax_r    <= '0;
          end
        end
        ST_PREP: begin
          state_r <= ST_MUL;
          phase_r <= PH_P;
          cnt_r   <= '0;
        end
        ST_MUL: begin
          if (cnt_r == CHUNK_W'(MUL_CHUNKS)) begin
            state_r <= ST_POST;
          end else begin
            cnt_r <= cnt_r + CHUNK_W'(1);
          end
        end
        ST_POST: begin
          cnt_r <= '0;
          unique case (phase_r)
            PH_P: begin
              state_r <= ST_MUL;
              phase_r <= PH_I1;
            end
            PH_I1: begin
              state_r <= ST_MUL;
              phase_r <= PH_I2;
            end
            PH_I2: begin
              state_r <= ST_DIV;
              phase_r <= PH_DIV_I;
            end
            PH_DIV_I: begin
              state_r <= ST_MUL;
              phase_r <= PH_D1;
            end
            PH_D1: begin
              state_r <= ST_MUL;
              phase_r <= PH_D2;
            end
            PH_D2: begin
              state_r <= ST_DIV;
              phase_r <= PH_DIV_D;
            end
            PH_DIV_D: state_r <= ST_SUM1;
            default:  state_r <= ST_IDLE;
          endcase
        end
        ST_DIV: begin
          if (stat.div_last) state_r <= ST_POST;
        end
        ST_SUM1: state_r <= ST_SUM2;
        ST_SUM2: begin
          if (ax_r == AX_W'(AXES - 1)) begin
            state_r <= ST_DONE;
          end else begin
            ax_r    <= ax_r + AX_W'(1);
            state_r <= ST_PREP;
          end
        end
        ST_DONE: begin
          if (pub_ok) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

FILE: src/tapv_datapath.sv
// gain registers, integral state, shared multiply and divide units, term sum
module tapv_datapath import tapv_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [31:0]                  cfg_data,
  input  logic [AXES-1:0][DATA_W-1:0]  err_in,
  input  logic [AXES-1:0][DATA_W-1:0]  perr_in,
  output logic [AXES-1:0][DATA_W-1:0]  vel_out
);

  logic [GAIN_W-1:0]             kp_r, ki_r, kd_r;
  logic [US_W-1:0]               us_r;
  logic [US_W-1:0]               us_eff;

  logic [AXES-1:0][DATA_W-1:0]   err_r, perr_r;
  logic [AXES-1:0][ACC_W-1:0]    acc_r;
  logic [AXES-1:0][DATA_W-1:0]   vw_r;
  logic [AXES-1:0][DATA_W-1:0]   vel_r;

  logic [DATA_W-1:0]             e_cur, ep_cur;
  logic [ACC_W-1:0]              acc_cur;
  logic [ACC_W:0]                acc_sum;
  logic [ACC_W-1:0]              acc_sat;
  logic [DATA_W-1:0]             e_mag;
  logic [ACC_W-1:0]              acc_mag;
  logic [D_W-1:0]                d_nxt, d_mag;
  logic [D_W-1:0]                d_r;
  logic                          e_neg_r;

  logic [MULA_W-1:0]             mul_a_r;
  logic [GAIN_W-1:0]             mul_b_r;
  logic [31:0]                   a_chunk;
  logic                          mul_issue, mul_start;
  logic [PROD_W-1:0]             prod_r;
  logic [CHUNK_W-1:0]            prod_sh_r;
  logic                          prod_vld_r;
  logic [WACC_W-1:0]             wacc_r;
  logic [WACC_W-1:0]             prod_shifted;

  logic [DIV_W-1:0]              div_num_r, div_num_nxt;
  logic [DEN_W-1:0]              div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0]              div_den_r;
  logic [DIV_CNT_W-1:0]          div_cnt_r;

  logic [PMAG_W-1:0]             pmag_r;
  logic [MAG_W-1:0]              imag_r, dmag_r;
  logic [SUM_W-1:0]              sp, si, sd, sum_r, vsum;
  logic [DATA_W-1:0]             vsat;

  function automatic logic [MAG_W-1:0] cap_term(input logic [DIV_W-1:0] q);
    if (q > DIV_W'(TERM_CAP)) return TERM_CAP;
    return q[MAG_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] apply_sign(input logic neg, input logic [SUM_W-1:0] m);
    return neg ? (~m + SUM_W'(1)) : m;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= KP_RESET;
      ki_r <= KI_RESET;
      kd_r <= KD_RESET;
      us_r <= US_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KP:     kp_r <= cfg_data[GAIN_W-1:0];
        CFG_KI:     ki_r <= cfg_data[GAIN_W-1:0];
        CFG_KD:     kd_r <= cfg_data[GAIN_W-1:0];
        CFG_PERIOD: us_r <= cfg_data[US_W-1:0];
      endcase
    end
  end

  // a zero period counts as one microsecond
  assign us_eff = (us_r == '0) ? US_W'(1) : us_r;

  // current axis operands
  assign e_cur   = err_r[cmd.axis];
  assign ep_cur  = perr_r[cmd.axis];
  assign acc_cur = acc_r[cmd.axis];

  // integral update with saturation, derivative and magnitudes
  always_comb begin
    acc_sum = {acc_cur[ACC_W-1], acc_cur}
            + {{(ACC_W+1-DATA_W){e_cur[DATA_W-1]}}, e_cur};
    if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
      acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_sum[ACC_W-1:0];
    end
    d_nxt   = {e_cur[DATA_W-1], e_cur} - {ep_cur[DATA_W-1], ep_cur};
    e_mag   = e_cur[DATA_W-1] ? (~e_cur + DATA_W'(1)) : e_cur;
    acc_mag = acc_cur[ACC_W-1] ? (~acc_cur + ACC_W'(1)) : acc_cur;
    d_mag   = d_r[D_W-1] ? (~d_r + D_W'(1)) : d_r;
  end

  // multiplier chunk select
  always_comb begin
    case (cmd.chunk)
      2'd0:    a_chunk = mul_a_r[31:0];
      2'd1:    a_chunk = mul_a_r[63:32];
      2'd2:    a_chunk = mul_a_r[95:64];
      default: a_chunk = '0;
    endcase
  end

  assign mul_issue = (cmd.op == OP_MUL) && (cmd.chunk != CHUNK_W'(MUL_CHUNKS));
  assign mul_start = (cmd.op == OP_PREP) || (cmd.op == OP_POST_P) ||
                     (cmd.op == OP_POST_I1) || (cmd.op == OP_POST_DIV_I) ||
                     (cmd.op == OP_POST_D1);
  assign prod_shifted = {{(WACC_W-PROD_W){1'b0}}, prod_r} << {prod_sh_r, 5'b0};

  // registered partial product, accumulated in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= mul_issue;
    end
    if (mul_issue) begin
      prod_r    <= a_chunk * mul_b_r;
      prod_sh_r <= cmd.chunk;
    end
    if (mul_start) begin
      wacc_r <= '0;
    end else if (prod_vld_r) begin
      wacc_r <= wacc_r + prod_shifted;
    end
  end

  // divider: four restoring steps per cycle
  always_comb begin
    logic [DEN_W:0] r_t;
    div_num_nxt = div_num_r;
    div_rem_nxt = div_rem_r;
    for (int j = 0; j < DIV_STEP; j++) begin
      r_t         = {div_rem_nxt, div_num_nxt[DIV_W-1]};
      div_num_nxt = {div_num_nxt[DIV_W-2:0], 1'b0};
      if (r_t >= {1'b0, div_den_r}) begin
        div_rem_nxt    = DEN_W'(r_t - {1'b0, div_den_r});
        div_num_nxt[0] = 1'b1;
      end else begin
        div_rem_nxt = r_t[DEN_W-1:0];
      end
    end
  end

  assign stat.div_last = (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));

  // signed terms and the final saturating sum
  always_comb begin
    sp   = apply_sign(e_neg_r, SUM_W'(pmag_r));
    si   = apply_sign(acc_cur[ACC_W-1], SUM_W'(imag_r));
    sd   = apply_sign(d_r[D_W-1], SUM_W'(dmag_r));
    vsum = sum_r + sd;
    if ((vsum[SUM_W-1:DATA_W-1] == '0) || (vsum[SUM_W-1:DATA_W-1] == '1)) begin
      vsat = vsum[DATA_W-1:0];
    end else begin
      vsat = vsum[SUM_W-1] ? VEL_MIN : VEL_MAX;
    end
  end

  // integral state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.op == OP_PREP) begin
      acc_r[cmd.axis] <= acc_sat;
    end
  end

  // divider step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if ((cmd.op == OP_POST_I2) || (cmd.op == OP_POST_D2)) begin
      div_cnt_r <= '0;
    end else if (cmd.op == OP_DIV) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // operation sequencing of the payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_NONE, OP_MUL: begin
      end
      OP_LOAD: begin
        err_r  <= err_in;
        perr_r <= perr_in;
      end
      OP_PREP: begin
        d_r     <= d_nxt;
        e_neg_r <= e_cur[DATA_W-1];
        mul_a_r <= MULA_W'(e_mag);
        mul_b_r <= kp_r;
      end
      OP_POST_P: begin
        pmag_r  <= wacc_r[FRAC_BITS +: PMAG_W];
        mul_a_r <= MULA_W'(acc_mag);
        mul_b_r <= GAIN_W'(us_eff);
      end
      OP_POST_I1: begin
        mul_a_r <= wacc_r[MULA_W-1:0];
        mul_b_r <= ki_r;
      end
      OP_POST_I2: begin
        div_num_r <= wacc_r[I_DIV_SHIFT +: DIV_W];
        div_den_r <= DEN_W'(I_DIV_CONST);
        div_rem_r <= '0;
      end
      OP_POST_DIV_I: begin
        imag_r  <= cap_term(div_num_r);
        mul_a_r <= MULA_W'(d_mag);
        mul_b_r <= kd_r;
      end
      OP_POST_D1: begin
        mul_a_r <= wacc_r[MULA_W-1:0];
        mul_b_r <= GAIN_W'(MICRO_PER_SEC);
      end
      OP_POST_D2: begin
        div_num_r <= wacc_r[FRAC_BITS +: DIV_W];
        div_den_r <= us_eff;
        div_rem_r <= '0;
      end
      OP_POST_DIV_D: begin
        dmag_r <= cap_term(div_num_r);
      end
      OP_DIV: begin
        div_num_r <= div_num_nxt;
        div_rem_r <= div_rem_nxt;
      end
      OP_SUM1: begin
        sum_r <= sp + si;
      end
      OP_SUM2: begin
        vw_r[cmd.axis] <= vsat;
      end
      OP_PUBLISH: begin
        vel_r <= vw_r;
      end
      default: begin
      end
    endcase
  end

  assign vel_out = vel_r;

endmodule

FILE: src/three_axis_pid_velocity_unit.sv
// top level of the three-axis pid velocity unit
//
//  channel  direction  handshake        payload
//  in_      input      valid / stall    current and previous error, three axes
//  out_     output     valid / stall    velocity command, three axes
//  cfg_     input      valid / ready    register index, write data
//
// each item is worked on axis by axis: per axis a prep step, five chunked
// multiplies on the shared 32x32 multiplier, a setup step after each multiply
// and divide, two divides on the shared radix-16 divider and the term sum;
// the next item is taken when the sequencer is back in idle.
// synchronous active-low reset restores the gains, the period and clears the
// integral accumulators. a stalled result holds in its output register while
// the next item is taken and worked on; the sequencer waits before publishing.
module three_axis_pid_velocity_unit import tapv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_error_axis0,
  input  logic signed [31:0]   in_error_axis1,
  input  logic signed [31:0]   in_error_axis2,
  input  logic signed [31:0]   in_prev_error_axis0,
  input  logic signed [31:0]   in_prev_error_axis1,
  input  logic signed [31:0]   in_prev_error_axis2,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_velocity_axis0,
  output logic signed [31:0]   out_velocity_axis1,
  output logic signed [31:0]   out_velocity_axis2,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t                     cmd;
  dp_stat_t                    stat;
  logic [AXES-1:0][DATA_W-1:0] err_in, perr_in, vel;

  assign cfg_ready = 1'b1;

  // pack the axis fields
  assign err_in[0]  = in_error_axis0;
  assign err_in[1]  = in_error_axis1;
  assign err_in[2]  = in_error_axis2;
  assign perr_in[0] = in_prev_error_axis0;
  assign perr_in[1] = in_prev_error_axis1;
  assign perr_in[2] = in_prev_error_axis2;

  assign out_velocity_axis0 = vel[0];
  assign out_velocity_axis1 = vel[1];
  assign out_velocity_axis2 = vel[2];

  tapv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  tapv_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .err_in    (err_in),
    .perr_in   (perr_in),
    .vel_out   (vel)
  );

endmodule

FILE: src/tapv_checker.sv
// port-level checks of the pid velocity unit and their bind
module tapv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_velocity_axis0,
  input logic [31:0] out_velocity_axis1,
  input logic [31:0] out_velocity_axis2
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_velocity_axis0) &&
      $stable(out_velocity_axis1) && $stable(out_velocity_axis2))
    else $error("result changed while stalled");

  // an accepted item closes the input right after its transfer
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind three_axis_pid_velocity_unit tapv_checker u_tapv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_velocity_axis0 (out_velocity_axis0),
  .out_velocity_axis1 (out_velocity_axis1),
  .out_velocity_axis2 (out_velocity_axis2)
);
